// ----- hw/rtl/dbd_pkg.sv -----
`timescale 1ns / 1ps

package dbd_pkg;

	localparam int COUNT_W = 21;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int REM_W = 9;
	localparam logic [REM_W-1:0] REM_MOD = 9'd400;
	localparam logic [REM_W-1:0] REM_LAST = 9'd399;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REM,
		S_SMON,
		S_YEAR,
		S_EMON,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rem_step;
		logic mon_init;
		logic mon_step;
		logic mon_end;
		logic year_step;
		logic finish;
	} dbd_cmd_t;

	typedef struct packed {
		logic rem_last;
		logic mon_done;
		logic year_done;
		logic ordered;
	} dbd_stat_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// leap test on the year modulo 400
	function automatic logic leap_of(input logic [REM_W-1:0] r);
		return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

endpackage

// ----- hw/rtl/dbd_ctrl.sv -----
`timescale 1ns / 1ps

module dbd_ctrl
	import dbd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_free,
	input  dbd_stat_t stat,
	output logic      in_ready,
	output dbd_cmd_t  cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nxt = S_REM;
				end
			end
			S_REM: begin
				cmd.rem_step = 1'b1;
				if (stat.rem_last) begin
					cmd.mon_init = 1'b1;
					state_nxt = stat.ordered ? S_SMON : S_DONE;
				end
			end
			S_SMON: begin
				if (stat.mon_done) begin
					state_nxt = S_YEAR;
				end else begin
					cmd.mon_step = 1'b1;
				end
			end
			S_YEAR: begin
				if (stat.year_done) begin
					cmd.mon_init = 1'b1;
					state_nxt = S_EMON;
				end else begin
					cmd.year_step = 1'b1;
				end
			end
			S_EMON: begin
				cmd.mon_end = 1'b1;
				if (stat.mon_done) begin
					state_nxt = S_DONE;
				end else begin
					cmd.mon_step = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/dbd_dp.sv -----
`timescale 1ns / 1ps

module dbd_dp
	import dbd_pkg::*;
#(
	parameter int YEAR_BITS = 12
) (
	input  logic                 clk,
	input  dbd_cmd_t             cmd,
	input  logic [YEAR_BITS-1:0] start_year,
	input  logic [MONTH_W-1:0]   start_month,
	input  logic [DAY_W-1:0]     start_day,
	input  logic [YEAR_BITS-1:0] end_year,
	input  logic [MONTH_W-1:0]   end_month,
	input  logic [DAY_W-1:0]     end_day,
	input  logic                 include_end,
	output dbd_stat_t            stat,
	output logic [COUNT_W-1:0]   day_count
);

	localparam int ACC_W = (YEAR_BITS + 11 > COUNT_W + 1) ? YEAR_BITS + 11 : COUNT_W + 1;
	localparam int QP_W = 24;
	localparam int QUO_W = 8;
	localparam int RECIP_SH = 15;
	// year / 400 = (year >> 4) / 25, and for a value below 4096 the quotient
	// by 25 is (value * 1311) >> 15
	localparam logic [QP_W-1:0] RECIP_25 = 24'd1311;

	logic [YEAR_BITS-1:0] sy_q, ey_q, y_q;
	logic [MONTH_W-1:0]   sm_q, em_q, mi_q;
	logic                 inc_q, ordered_q;
	logic [REM_W-1:0]     r400_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 rem_ph_q;
	logic [ACC_W-1:0]     acc_q;

	logic                 ordered;
	logic [QP_W-1:0]      quo_prod;
	logic [QP_W-1:0]      quo_back;
	logic [QP_W-1:0]      rem_full;
	logic [MONTH_W-1:0]   mon_lim;
	logic                 leap;
	logic [DAY_W-1:0]     mlen;
	logic [ACC_W:0]       span;
	logic [ACC_W:0]       total;

	always_comb begin
		if (start_year != end_year) begin
			ordered = start_year < end_year;
		end else if (start_month != end_month) begin
			ordered = start_month < end_month;
		end else begin
			ordered = start_day < end_day;
		end
	end

	// start year modulo 400 in two steps: quotient first, then the remainder
	assign quo_prod = QP_W'(sy_q[YEAR_BITS-1:4]) * RECIP_25;
	assign quo_back = QP_W'(quo_q) * QP_W'(REM_MOD);
	assign rem_full = QP_W'(sy_q) - quo_back;

	assign leap    = leap_of(r400_q);
	assign mon_lim = cmd.mon_end ? em_q : sm_q;
	assign mlen    = month_len(mi_q, leap);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sy_q      <= start_year;
			ey_q      <= end_year;
			y_q       <= start_year;
			sm_q      <= start_month;
			em_q      <= end_month;
			inc_q     <= include_end;
			ordered_q <= ordered;
			rem_ph_q  <= 1'b0;
			acc_q     <= ACC_W'(end_day) - ACC_W'(start_day);
		end
		if (cmd.rem_step) begin
			if (!rem_ph_q) begin
				quo_q    <= quo_prod[RECIP_SH +: QUO_W];
				rem_ph_q <= 1'b1;
			end else begin
				r400_q <= rem_full[REM_W-1:0];
			end
		end
		if (cmd.mon_init) begin
			mi_q <= 4'd1;
		end
		if (cmd.mon_step) begin
			mi_q  <= mi_q + 1'b1;
			acc_q <= cmd.mon_end ? acc_q + ACC_W'(mlen) : acc_q - ACC_W'(mlen);
		end
		if (cmd.year_step) begin
			y_q    <= y_q + 1'b1;
			r400_q <= (r400_q == REM_LAST) ? '0 : r400_q + 1'b1;
			acc_q  <= acc_q + (leap ? ACC_W'(366) : ACC_W'(365));
		end
	end

	assign stat.rem_last  = rem_ph_q;
	assign stat.mon_done  = !((mi_q < mon_lim) && (mi_q <= MONTH_DEC));
	assign stat.year_done = (y_q == ey_q);
	assign stat.ordered   = ordered_q;

	// clamp a negative or unordered span to zero, add one if the end day counts, saturate
	assign span  = (ordered_q && !acc_q[ACC_W-1]) ? {1'b0, acc_q} : '0;
	assign total = span + (ACC_W+1)'(inc_q);
	assign day_count = (total > (ACC_W+1)'(COUNT_MAX)) ? COUNT_MAX : total[COUNT_W-1:0];

endmodule

// ----- hw/rtl/days_between_dates.sv -----
// Flow: load the beat, reduce the start year modulo 400, then, for an ordered pair,
//   walk the start month, the years and the end month before the result is valid;
//   a month walk takes month - 1 steps, at most 12; the year walk sets the worst case.
// Throughput: one item at a time; the next beat is taken only after the result
//   moves to the output register, which may still wait on m_axis_tready.
// Reset: arst_n asynchronous active low; clears the controller and the output valid.
`timescale 1ns / 1ps

module days_between_dates
	import dbd_pkg::*;
#(
	parameter int YEAR_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata from bit 0: start_year, start_month, start_day, end_year, end_month,
	// end_day, include_end, zero fill to whole bytes
	input  logic [((2*YEAR_BITS+19+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// tdata from bit 0: day_count, zero fill to whole bytes
	output logic [((COUNT_W+7)/8)*8-1:0] m_axis_tdata
);

	localparam int OUT_W = ((COUNT_W + 7) / 8) * 8;
	localparam int SM_LO = YEAR_BITS;
	localparam int SD_LO = SM_LO + MONTH_W;
	localparam int EY_LO = SD_LO + DAY_W;
	localparam int EM_LO = EY_LO + YEAR_BITS;
	localparam int ED_LO = EM_LO + MONTH_W;
	localparam int IE_LO = ED_LO + DAY_W;

	dbd_cmd_t           cmd;
	dbd_stat_t          stat;
	logic               out_free;
	logic [COUNT_W-1:0] result;
	logic               out_valid_q;
	logic [COUNT_W-1:0] out_data_q;

	// the output register frees up in the same cycle its beat is taken
	assign out_free = !out_valid_q || m_axis_tready;

	dbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	// datapath: remainder by 400; the month walks and the year walk share one accumulator
	dbd_dp #(
		.YEAR_BITS (YEAR_BITS)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.start_year  (s_axis_tdata[SM_LO-1:0]),
		.start_month (s_axis_tdata[SD_LO-1:SM_LO]),
		.start_day   (s_axis_tdata[EY_LO-1:SD_LO]),
		.end_year    (s_axis_tdata[EM_LO-1:EY_LO]),
		.end_month   (s_axis_tdata[ED_LO-1:EM_LO]),
		.end_day     (s_axis_tdata[IE_LO-1:ED_LO]),
		.include_end (s_axis_tdata[IE_LO]),
		.stat        (stat),
		.day_count   (result)
	);

	// output register: load on finish, drop valid once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_axis_tready))
		else $error("result loaded over an untaken beat");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while an item is in work");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("output valid without a finished item");

endmodule

// ----- tb/days_between_dates_tb.sv -----
`timescale 1ns / 1ps

module days_between_dates_tb;
	import dbd_pkg::*;

	localparam int YEAR_W = 12;
	localparam int YEAR_TOP = (1 << YEAR_W) - 1;
	localparam int S_DATA_W = ((2*YEAR_W+19+7)/8)*8;
	localparam int M_DATA_W = ((COUNT_W+7)/8)*8;
	// long receiver hold-off; long enough for the block to finish its
	// current date pair, park it in the output register and take another
	localparam int LONG_HOLD_CYCLES = 10000;
	// settle time after the last result: the slowest year walk plus margin
	localparam int TAIL_CYCLES = 4200;
	// watchdog in ns: several times the slowest legal run
	localparam longint WATCHDOG_NS = 64'd12_000_000;

	typedef struct {
		logic [YEAR_W-1:0]  start_year;
		logic [MONTH_W-1:0] start_month;
		logic [DAY_W-1:0]   start_day;
		logic [YEAR_W-1:0]  end_year;
		logic [MONTH_W-1:0] end_month;
		logic [DAY_W-1:0]   end_day;
		logic               include_end;
		bit                 wait_drain;   // hold this beat until nothing is owed
	} date_query_t;

	typedef struct {
		date_query_t        query;
		logic [COUNT_W-1:0] day_count;
	} date_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;

	date_query_t  queued_queries[$];   // filled by the stimulus process
	date_answer_t owed_day_counts[$];  // one per accepted input beat
	date_query_t  query_on_wire;

	int error_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;

	days_between_dates #(
		.YEAR_BITS(YEAR_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		// from bit 0: start_year, start_month, start_day, end_year, end_month,
		// end_day, include_end, zero fill
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		// from bit 0: day_count, zero fill
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Calendar arithmetic for the expected day count
	// ---------------------------------------------------------------

	// Gregorian rule: every 4th year, except centuries not divisible by 400
	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// months outside 1..12 have no length, so 13..15 add nothing past December
	function automatic int unsigned month_days(input int unsigned m, input bit leap);
		int unsigned n;
		case (m)
			1, 3, 5, 7, 8, 10, 12: n = 31;
			4, 6, 9, 11: n = 30;
			2: n = leap ? 29 : 28;
			default: n = 0;
		endcase
		return n;
	endfunction

	// day is taken as is, even when it does not fit its month
	function automatic int unsigned ordinal_day(input int unsigned y, input int unsigned m,
			input int unsigned d);
		int unsigned sum;
		sum = d;
		for (int unsigned i = 1; i < m && i <= 12; i++)
			sum += month_days(i, leap_year(y));
		return sum;
	endfunction

	function automatic logic [COUNT_W-1:0] days_spanned(input date_query_t q);
		longint span;
		bit ordered;
		span = 0;
		// compare year, then month, then day
		if (q.start_year != q.end_year)
			ordered = q.start_year < q.end_year;
		else if (q.start_month != q.end_month)
			ordered = q.start_month < q.end_month;
		else
			ordered = q.start_day < q.end_day;
		if (ordered) begin
			span = longint'(ordinal_day(q.end_year, q.end_month, q.end_day))
				- longint'(ordinal_day(q.start_year, q.start_month, q.start_day));
			for (int unsigned y = q.start_year; y < q.end_year; y++)
				span += leap_year(y) ? 366 : 365;
			// bad days can push the span below zero; clamp before the flag
			if (span < 0)
				span = 0;
		end
		span += longint'(q.include_end);
		if (span > longint'(COUNT_MAX))
			span = longint'(COUNT_MAX);
		return span[COUNT_W-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Stimulus building
	// ---------------------------------------------------------------

	task automatic add_query(input int sy, input int sm, input int sd, input int ey,
			input int em, input int ed, input bit inc);
		date_query_t q;
		q.start_year = YEAR_W'(sy);
		q.start_month = MONTH_W'(sm);
		q.start_day = DAY_W'(sd);
		q.end_year = YEAR_W'(ey);
		q.end_month = MONTH_W'(em);
		q.end_day = DAY_W'(ed);
		q.include_end = inc;
		q.wait_drain = 1'b0;
		queued_queries.push_back(q);
	endtask

	function automatic date_query_t make_random_query();
		date_query_t q;
		int kind;
		int sy;
		int ey;
		kind = $urandom_range(0, 99);
		sy = $urandom_range(0, YEAR_TOP);
		q.start_month = MONTH_W'($urandom_range(1, 12));
		q.start_day = DAY_W'($urandom_range(1, 31));
		q.end_month = MONTH_W'($urandom_range(1, 12));
		q.end_day = DAY_W'($urandom_range(1, 31));
		q.include_end = 1'($urandom_range(0, 1));
		q.wait_drain = 1'b0;
		if (kind < 60) begin
			// ordinary forward span of a few years
			ey = sy + $urandom_range(0, 12);
		end else if (kind < 75) begin
			// end year at or before the start year; sometimes the very same date
			ey = sy - $urandom_range(0, 3);
			if (ey < 0)
				ey = 0;
			if ($urandom_range(0, 2) == 0) begin
				ey = sy;
				q.end_month = q.start_month;
				q.end_day = q.start_day;
			end
		end else if (kind < 93) begin
			// out-of-range months and days, same or nearby year
			ey = sy + $urandom_range(0, 2);
			q.start_month = MONTH_W'($urandom_range(0, 15));
			q.start_day = DAY_W'($urandom_range(0, 31));
			q.end_month = MONTH_W'($urandom_range(0, 15));
			q.end_day = DAY_W'($urandom_range(0, 31));
			if (kind < 84)
				ey = sy;
		end else begin
			// long year walk; keep these few
			sy = $urandom_range(0, 255);
			ey = $urandom_range(YEAR_TOP - 300, YEAR_TOP);
		end
		if (ey > YEAR_TOP)
			ey = YEAR_TOP;
		q.start_year = YEAR_W'(sy);
		q.end_year = YEAR_W'(ey);
		return q;
	endfunction

	task automatic run_phase(input int send_pct, input int recv_pct, input int count,
			input bit long_hold);
		date_query_t q;
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (long_hold)
			hold_requests++;
		for (int i = 0; i < count; i++) begin
			q = make_random_query();
			// first beat of each phase waits for the previous phase to drain,
			// except under a long hold, where the sender keeps offering
			q.wait_drain = (i == 0) && !long_hold;
			queued_queries.push_back(q);
		end
		while (queued_queries.size() != 0)
			@(negedge clk);
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t MISMATCH: %s", $realtime, what);
		error_count++;
	endtask

	// ---------------------------------------------------------------
	// Input driver: advance to the next queued date pair once the current
	// beat is taken, with random idle cycles
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				owed_day_counts.push_back('{query_on_wire, days_spanned(query_on_wire)});
			if (!s_axis_tvalid || s_axis_tready) begin
				if (queued_queries.size() != 0
						&& (!queued_queries[0].wait_drain || owed_day_counts.size() == 0)
						&& $urandom_range(0, 99) >= send_idle_pct) begin
					query_on_wire = queued_queries.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= S_DATA_W'({query_on_wire.include_end,
						query_on_wire.end_day, query_on_wire.end_month,
						query_on_wire.end_year, query_on_wire.start_day,
						query_on_wire.start_month, query_on_wire.start_year});
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result monitor: check each beat against the oldest owed count, then
	// pick tready for the next edge (long hold first, else random stall)
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_day_counts.size() == 0) begin
					report_mismatch($sformatf("unexpected result day_count=%0d",
						m_axis_tdata[COUNT_W-1:0]));
				end else begin
					date_answer_t a;
					a = owed_day_counts.pop_front();
					if (m_axis_tdata[COUNT_W-1:0] !== a.day_count)
						report_mismatch($sformatf(
							"%0d-%0d-%0d to %0d-%0d-%0d inc=%0d: day_count %0d, want %0d",
							a.query.start_year, a.query.start_month, a.query.start_day,
							a.query.end_year, a.query.end_month, a.query.end_day,
							a.query.include_end, m_axis_tdata[COUNT_W-1:0], a.day_count));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence: reset, directed dates, then random phases
	// ---------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// whole year range, both flag values
		add_query(0, 1, 1, YEAR_TOP, 12, 31, 1);
		add_query(0, 1, 1, YEAR_TOP, 12, 31, 0);
		// widest field values from all-zero to all-ones
		add_query(0, 0, 0, YEAR_TOP, 15, 31, 1);
		// same date: count is just the flag
		add_query(2024, 6, 15, 2024, 6, 15, 1);
		add_query(2024, 6, 15, 2024, 6, 15, 0);
		add_query(YEAR_TOP, 15, 31, YEAR_TOP, 15, 31, 1);
		add_query(0, 0, 0, 0, 0, 0, 0);
		// start after end by year, by month, by day
		add_query(2025, 1, 1, 2024, 12, 31, 1);
		add_query(2024, 7, 1, 2024, 6, 30, 1);
		add_query(2024, 6, 16, 2024, 6, 15, 0);
		// leap rules: divisible by 400, century, plain, year zero
		add_query(2000, 2, 28, 2000, 3, 1, 0);
		add_query(1900, 2, 28, 1900, 3, 1, 0);
		add_query(2024, 1, 1, 2025, 1, 1, 0);
		add_query(2023, 1, 1, 2024, 1, 1, 1);
		add_query(0, 2, 28, 0, 3, 1, 0);
		add_query(399, 12, 31, 400, 1, 1, 0);
		// month zero and months past December
		add_query(100, 0, 5, 100, 1, 5, 0);
		add_query(100, 13, 1, 100, 15, 31, 0);
		add_query(100, 12, 31, 100, 15, 0, 1);
		add_query(YEAR_TOP, 12, 31, YEAR_TOP, 15, 31, 1);
		// day zero, and a bad day that drives the span negative
		add_query(2001, 3, 0, 2001, 3, 31, 0);
		add_query(2001, 2, 31, 2001, 3, 0, 1);
		add_query(2001, 2, 31, 2001, 3, 0, 0);
		while (queued_queries.size() != 0)
			@(negedge clk);

		// no idling, with one long receiver hold-off to back the block up
		run_phase(0, 0, 30, 1'b1);
		run_phase(62, 0, 30, 1'b0);
		run_phase(0, 62, 30, 1'b0);
		run_phase(27, 27, 30, 1'b0);

		while (queued_queries.size() != 0 || s_axis_tvalid || owed_day_counts.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("days_between_dates_tb: clean");
		else
			$display("days_between_dates_tb: errors");
		$finish;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("days_between_dates_tb: errors");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/dbd_pkg.sv
hw/rtl/dbd_ctrl.sv
hw/rtl/dbd_dp.sv
hw/rtl/days_between_dates.sv
tb/days_between_dates_tb.sv
